// ===== hw/rtl/aopc_pkg.sv =====
// ----------------------------------------------------------------------------
// aopc_pkg
// Shared types, codes and helpers for the alpha-over pixel compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package aopc_pkg;

    localparam int unsigned DEF_MAX_CANVAS_WIDTH  = 256;
    localparam int unsigned DEF_MAX_CANVAS_HEIGHT = 256;

    localparam int unsigned DIM_W     = 9;    // canvas_width / canvas_height
    localparam int unsigned COORD_W   = 10;   // signed pixel_x / pixel_y
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned S_TDATA_W = 56;   // 52 payload bits padded to bytes
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

    // Item kinds
    localparam logic KIND_BLEND = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OPAQUE = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BLEND  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SKIP   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLIP   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_READ   = 3'd4;

    // Canvas word: red in the low byte, alpha in the high byte
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WRITE
    } state_t;

    // Exact v/255 for v up to 65279 (mix sums stay at or below 255*255)
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

endpackage : aopc_pkg

`default_nettype wire

// ===== hw/rtl/alpha_over_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// alpha_over_pixel_compositor
// Composites RGBA source pixels into a canvas store held in one RAM.
// ----------------------------------------------------------------------------
// Items: each accepted item goes through address, RAM read, mix and write
//   back of the same canvas word before the result is registered and the
//   next item is taken; write back waits while the result register is held.
// Reset: aresetn is synchronous. After it the block sweeps all canvas words,
//   MAX_CANVAS_WIDTH*MAX_CANVAS_HEIGHT (65536 by default), to zero, one word
//   a cycle, with s_tready low. Config writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_over_pixel_compositor #(
    parameter int unsigned MAX_CANVAS_WIDTH  = aopc_pkg::DEF_MAX_CANVAS_WIDTH,
    parameter int unsigned MAX_CANVAS_HEIGHT = aopc_pkg::DEF_MAX_CANVAS_HEIGHT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [aopc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aopc_pkg::DIM_W-1:0]       cfg_data,

    // Input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] src_red, [35:28] src_green,
    // [43:36] src_blue, [51:44] src_alpha, [55:52] zero
    input  wire logic [aopc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  wire logic                             s_tuser,

    // Result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    output logic [aopc_pkg::M_TDATA_W-1:0]        m_tdata,
    // [2:0] status
    output logic [aopc_pkg::STATUS_W-1:0]         m_tuser
);
    import aopc_pkg::*;

    localparam int unsigned DEPTH  = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned SUM_W  = 2 * DIM_W + 1;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [DIM_W-1:0]     width_reg, width_next;
    logic [DIM_W-1:0]     height_reg, height_next;
    logic                 out_valid_reg, out_valid_next;

    // Item payload, held for the whole read-modify-write
    logic                 kind_reg;
    logic [COORD_W-1:0]   x_reg, y_reg;
    pixel_t               src_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 clip_reg;
    pixel_t               dst_reg;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    pixel_t               out_pix_reg, out_pix_next;

    // Handshake strobes
    logic                 in_fire;
    logic                 out_free;

    // Address path
    logic [DIM_W-1:0]     w_eff, h_eff;
    logic [2*DIM_W-1:0]   row_base;
    logic [SUM_W-1:0]     lin_addr;
    logic [ADDR_W-1:0]    addr_calc;
    logic                 clip_calc;

    // RAM and mixer
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [PIX_W-1:0]     ram_wr_data;
    logic                 ram_rd_en;
    logic [PIX_W-1:0]     ram_rd_data;
    pixel_t               ram_pix;
    pixel_t               mixed_pix;
    logic                 blend_load;
    logic                 wb_write;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid & s_tready;
    assign out_free  = ~out_valid_reg | m_tready;
    assign ram_pix   = pixel_t'(ram_rd_data);

    // ------------------------------------------------------------------
    // Config registers; zero acts as one, above the store size as max
    // ------------------------------------------------------------------
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:  width_next  = cfg_data;
                CFG_CANVAS_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(width_reg) > MAX_CANVAS_WIDTH) begin
            w_eff = DIM_W'(MAX_CANVAS_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(height_reg) > MAX_CANVAS_HEIGHT) begin
            h_eff = DIM_W'(MAX_CANVAS_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Clip test and linear address (row * width + column)
    // ------------------------------------------------------------------
    always_comb begin
        clip_calc = x_reg[COORD_W-1] | y_reg[COORD_W-1]
                  | (x_reg[DIM_W-1:0] >= w_eff)
                  | (y_reg[DIM_W-1:0] >= h_eff);
        row_base  = y_reg[DIM_W-1:0] * w_eff;
        lin_addr  = SUM_W'(row_base) + SUM_W'(x_reg[DIM_W-1:0]);
        if (32'(lin_addr) >= DEPTH) begin
            addr_calc = ADDR_W'(DEPTH - 1);
        end else begin
            addr_calc = ADDR_W'(lin_addr);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready     = 1'b0;
        ram_rd_en    = 1'b0;
        blend_load   = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = addr_reg;
        ram_wr_data  = out_pix_next;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:  s_tready   = 1'b1;
            ST_ADDR:  ram_rd_en  = ~clip_calc;
            ST_READ:  blend_load = 1'b1;
            ST_WRITE: ram_wr_en  = out_free & wb_write;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result selection and write-back data
    // ------------------------------------------------------------------
    always_comb begin
        wb_write        = 1'b0;
        out_status_next = STATUS_READ;
        out_pix_next    = dst_reg;
        if (clip_reg) begin
            out_status_next = STATUS_CLIP;
            out_pix_next    = '0;
        end else if (kind_reg == KIND_READ) begin
            out_status_next = STATUS_READ;
        end else if (src_reg.alpha == ALPHA_CLEAR) begin
            out_status_next = STATUS_SKIP;
        end else if (src_reg.alpha == ALPHA_OPAQUE) begin
            out_status_next = STATUS_OPAQUE;
            out_pix_next    = src_reg;
            wb_write        = 1'b1;
        end else begin
            out_status_next = STATUS_BLEND;
            out_pix_next    = mixed_pix;
            wb_write        = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_WRITE && out_free) begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            width_reg     <= DIM_W'(256);
            height_reg    <= DIM_W'(256);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            kind_reg      <= s_tuser;
            x_reg         <= s_tdata[9:0];
            y_reg         <= s_tdata[19:10];
            src_reg.red   <= s_tdata[27:20];
            src_reg.green <= s_tdata[35:28];
            src_reg.blue  <= s_tdata[43:36];
            src_reg.alpha <= s_tdata[51:44];
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= addr_calc;
            clip_reg <= clip_calc;
        end
        if (state_reg == ST_READ) begin
            dst_reg <= ram_pix;
        end
        if (state_reg == ST_WRITE && out_free) begin
            out_status_reg <= out_status_next;
            out_pix_reg    <= out_pix_next;
        end
    end

    // ------------------------------------------------------------------
    // Canvas store and mixer
    // ------------------------------------------------------------------
    aopc_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_canvas (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_calc),
        .rd_data (ram_rd_data)
    );

    aopc_blend u_blend (
        .aclk  (aclk),
        .load  (blend_load),
        .src   (src_reg),
        .dst   (ram_pix),
        .mixed (mixed_pix)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_pix_reg);
    assign m_tuser  = out_status_reg;

endmodule : alpha_over_pixel_compositor

`default_nettype wire

// ===== hw/rtl/aopc_ram.sv =====
// ----------------------------------------------------------------------------
// aopc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module aopc_ram #(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : aopc_ram

`default_nettype wire

// ===== hw/rtl/aopc_blend.sv =====
// ----------------------------------------------------------------------------
// aopc_blend
// Straight alpha-over mix: products registered, then divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module aopc_blend (
    input  wire logic              aclk,
    input  wire logic              load,
    input  wire aopc_pkg::pixel_t  src,
    input  wire aopc_pkg::pixel_t  dst,
    output aopc_pkg::pixel_t       mixed
);
    import aopc_pkg::*;

    logic [15:0]       sum_r_reg, sum_g_reg, sum_b_reg;
    logic [15:0]       sum_r_next, sum_g_next, sum_b_next;
    logic [CHAN_W-1:0] alpha_reg, alpha_next;
    logic [CHAN_W-1:0] inv_a;

    always_comb begin
        inv_a      = ALPHA_OPAQUE - src.alpha;
        sum_r_next = 16'(src.red)   * 16'(src.alpha) + 16'(dst.red)   * 16'(inv_a);
        sum_g_next = 16'(src.green) * 16'(src.alpha) + 16'(dst.green) * 16'(inv_a);
        sum_b_next = 16'(src.blue)  * 16'(src.alpha) + 16'(dst.blue)  * 16'(inv_a);
        alpha_next = (dst.alpha > src.alpha) ? dst.alpha : src.alpha;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            alpha_reg <= alpha_next;
        end
    end

    always_comb begin
        mixed.red   = div255(sum_r_reg);
        mixed.green = div255(sum_g_reg);
        mixed.blue  = div255(sum_b_reg);
        mixed.alpha = alpha_reg;
    end

endmodule : aopc_blend

`default_nettype wire

// ===== hw/rtl/aopc_checker.sv =====
// ----------------------------------------------------------------------------
// aopc_checker
// Port-level checks for the alpha-over pixel compositor.
// ----------------------------------------------------------------------------
`default_nettype none

module aopc_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [aopc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aopc_pkg::DIM_W-1:0]       cfg_data,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [aopc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [aopc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [aopc_pkg::STATUS_W-1:0]    m_tuser
);
    import aopc_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // Clipped results carry a zero pixel
    a_clip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_CLIP) |-> (m_tdata == '0))
        else $error("clipped result with nonzero pixel");

    // Opaque writes leave the canvas alpha at full
    a_opaque_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OPAQUE) |-> (m_tdata[31:24] == ALPHA_OPAQUE))
        else $error("opaque write without full alpha");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity right after reset");

endmodule : aopc_checker

bind alpha_over_pixel_compositor aopc_checker u_aopc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire

// ===== verif/compositor_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compositor_scoreboard_pkg
// Canvas model and in-order result checker for the alpha-over compositor
// bench. Mirrors the canvas store and active size, predicts one result per
// accepted item and compares results field by field.
// ----------------------------------------------------------------------------
package compositor_scoreboard_pkg;
    import aopc_pkg::*;

    localparam int unsigned CANVAS_WORDS = DEF_MAX_CANVAS_WIDTH * DEF_MAX_CANVAS_HEIGHT;
    localparam int unsigned N_STATUS     = 5;

    class canvas_scoreboard;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            pixel_t              pix;
        } outcome_t;

        bit [PIX_W-1:0] canvas [CANVAS_WORDS];   // zero, as after the clear sweep
        int             width_reg  = 256;
        int             height_reg = 256;
        outcome_t       pending_q [$];
        int unsigned    errors;
        int unsigned    checked;
        int unsigned    by_status [N_STATUS];

        function int clamp_dim(int v, int max_v);
            if (v < 1)
                return 1;
            if (v > max_v)
                return max_v;
            return v;
        endfunction

        function int active_width();
            return clamp_dim(width_reg, DEF_MAX_CANVAS_WIDTH);
        endfunction

        function int active_height();
            return clamp_dim(height_reg, DEF_MAX_CANVAS_HEIGHT);
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
            case (idx)
                CFG_CANVAS_WIDTH:  width_reg  = val;
                CFG_CANVAS_HEIGHT: height_reg = val;
                default: ;
            endcase
        endfunction

        // straight alpha mix, truncating division
        function logic [CHAN_W-1:0] mix_channel(int unsigned s, int unsigned d,
                                                int unsigned a);
            return CHAN_W'((s * a + d * (255 - a)) / 255);
        endfunction

        function void note_item(input logic kind,
                                input logic signed [COORD_W-1:0] px, py,
                                input logic [CHAN_W-1:0] src_r, src_g, src_b, src_a);
            int       xi;
            int       yi;
            int       w;
            int       h;
            int       addr;
            pixel_t   pix;
            outcome_t res;
            xi  = px;
            yi  = py;
            w   = active_width();
            h   = active_height();
            pix = '0;
            if (xi < 0 || yi < 0 || xi >= w || yi >= h) begin
                res.status = STATUS_CLIP;
            end else begin
                addr = yi * w + xi;
                pix  = canvas[addr];
                if (kind == KIND_READ) begin
                    res.status = STATUS_READ;
                end else if (src_a == ALPHA_CLEAR) begin
                    res.status = STATUS_SKIP;
                end else if (src_a == ALPHA_OPAQUE) begin
                    res.status   = STATUS_OPAQUE;
                    pix          = {ALPHA_OPAQUE, src_b, src_g, src_r};
                    canvas[addr] = pix;
                end else begin
                    res.status   = STATUS_BLEND;
                    pix.red      = mix_channel(src_r, pix.red, src_a);
                    pix.green    = mix_channel(src_g, pix.green, src_a);
                    pix.blue     = mix_channel(src_b, pix.blue, src_a);
                    pix.alpha    = (pix.alpha > src_a) ? pix.alpha : src_a;
                    canvas[addr] = pix;
                end
            end
            res.pix = pix;
            pending_q.push_back(res);
        endfunction

        function void check_field(string name, logic [CHAN_W-1:0] want,
                                  logic [CHAN_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(input logic [STATUS_W-1:0] status, input pixel_t pix);
            outcome_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d pixel %08h",
                         $time, status, pix);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.status < N_STATUS)
                by_status[want.status]++;
            check_field("status", CHAN_W'(want.status), CHAN_W'(status));
            check_field("red", want.pix.red, pix.red);
            check_field("green", want.pix.green, pix.green);
            check_field("blue", want.pix.blue, pix.blue);
            check_field("alpha", want.pix.alpha, pix.alpha);
        endfunction
    endclass

endpackage : compositor_scoreboard_pkg

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alpha_over_pixel_compositor. After reset and the
// canvas clear sweep, a directed burst hits clipping edges, opaque, blended,
// transparent and read items; then random items run across a set of canvas
// sizes, including out-of-range register values. Both stream sides idle at
// random outside one calm phase; a canvas model checks every result in order.
// ----------------------------------------------------------------------------
module tb;
    import aopc_pkg::*;
    import compositor_scoreboard_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Limit is several times the reset clear sweep plus the item traffic
    // with idling.
    localparam int unsigned CYCLE_LIMIT       = 400_000;
    localparam int unsigned ITEMS_PER_SETTING = 145;
    localparam int unsigned DRAIN_CYCLES      = 16;
    localparam int unsigned N_SETTINGS        = 10;
    localparam int unsigned CALM_SETTING      = 4;      // no idling in this phase

    // Canvas sizes per phase. 0 acts as 1, anything above 256 acts as 256.
    // Width changes between phases also move which linear word a coordinate
    // lands on, so old contents show up at new places.
    localparam logic [DIM_W-1:0] WIDTH_SET  [N_SETTINGS] =
        '{9'd256, 9'd1, 9'd0, 9'd511, 9'd16, 9'd5, 9'd3, 9'd256, 9'd1, 9'd300};
    localparam logic [DIM_W-1:0] HEIGHT_SET [N_SETTINGS] =
        '{9'd256, 9'd1, 9'd0, 9'd511, 9'd8, 9'd300, 9'd17, 9'd1, 9'd256, 9'd2};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] src_red, [35:28] src_green,
    // [43:36] src_blue, [51:44] src_alpha, [55:52] zero
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // [0] kind
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    logic [M_TDATA_W-1:0] m_tdata;
    // [2:0] status
    logic [STATUS_W-1:0]  m_tuser;

    bit                   calm = 1'b0;  // both sides stay busy while set
    int unsigned          cycles;
    int unsigned          sent;

    canvas_scoreboard     sb = new;

    alpha_over_pixel_compositor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: also catches a block that never leaves its clear sweep.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d, %0d results outstanding",
                     cycles, sb.outstanding());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: drop tready about one cycle in ten unless in the calm phase.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 10);
    end

    // Every accepted result goes to the checker, oldest expectation first.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Writes width then height, holding cfg_valid across both items.
    task automatic set_canvas(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CANVAS_WIDTH;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_CANVAS_WIDTH, w);
        cfg_index <= CFG_CANVAS_HEIGHT;
        cfg_data  <= h;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_CANVAS_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // One input item. An optional gap comes first so tvalid is never
    // dropped and raised in the same step.
    task automatic send_item(input logic kind, input coord_t px, input coord_t py,
                             input logic [CHAN_W-1:0] r, g, b, a);
        if (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, a, b, g, r, py, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(kind, px, py, r, g, b, a);
        sent++;
    endtask

    // Sender holds off until the block has returned everything.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Mostly on canvas, with a tiny hot corner to stack blends on the same
    // word, some right at the clip edges, the rest any 10-bit pattern.
    function automatic coord_t pick_coord(int span);
        int pick;
        int hot;
        pick = $urandom_range(99);
        hot  = (span > 3) ? 3 : span;
        if (pick < 45)
            return coord_t'($urandom_range(span - 1, 0));
        if (pick < 70)
            return coord_t'($urandom_range(hot - 1, 0));
        if (pick < 85) begin
            case ($urandom_range(2))
                0:       return coord_t'(-1);
                1:       return coord_t'(span);
                default: return coord_t'(span - 1);
            endcase
        end
        return coord_t'($urandom_range(1023));
    endfunction

    function automatic logic [CHAN_W-1:0] pick_alpha();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return ALPHA_CLEAR;
        if (pick < 30)
            return ALPHA_OPAQUE;
        if (pick < 38)
            return pick[0] ? 8'd1 : 8'd254;
        return CHAN_W'($urandom);
    endfunction

    task automatic send_random();
        logic kind;
        kind = ($urandom_range(99) < 20) ? KIND_READ : KIND_BLEND;
        send_item(kind, pick_coord(sb.active_width()), pick_coord(sb.active_height()),
                  CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), pick_alpha());
    endtask

    // Directed burst on the full 256 x 256 canvas.
    task automatic run_directed();
        // fresh canvas reads back zero; reads clip too
        send_item(KIND_READ,  0,    0,    8'hff, 8'hff, 8'hff, 8'hff);
        send_item(KIND_READ,  -256, -256, 8'h00, 8'h00, 8'h00, 8'h00);
        // each clip edge and two far points, with sources that must not land
        send_item(KIND_BLEND, -1,   0,    8'h11, 8'h22, 8'h33, ALPHA_OPAQUE);
        send_item(KIND_BLEND, 0,    -1,   8'h11, 8'h22, 8'h33, ALPHA_OPAQUE);
        send_item(KIND_BLEND, 256,  0,    8'h11, 8'h22, 8'h33, ALPHA_OPAQUE);
        send_item(KIND_BLEND, 0,    256,  8'h11, 8'h22, 8'h33, ALPHA_OPAQUE);
        send_item(KIND_BLEND, 511,  511,  8'hff, 8'hff, 8'hff, ALPHA_OPAQUE);
        send_item(KIND_BLEND, -256, 511,  8'hff, 8'hff, 8'hff, 8'd128);
        // far corner: opaque write, read back, then transparent and mixes
        send_item(KIND_BLEND, 255,  255,  8'hff, 8'hff, 8'hff, ALPHA_OPAQUE);
        send_item(KIND_READ,  255,  255,  8'hff, 8'hff, 8'hff, 8'hff);
        send_item(KIND_BLEND, 255,  255,  8'h00, 8'h00, 8'h00, ALPHA_CLEAR);
        send_item(KIND_BLEND, 255,  255,  8'h00, 8'h00, 8'h00, 8'd128);
        send_item(KIND_BLEND, 255,  255,  8'h00, 8'h7f, 8'hff, 8'd1);
        send_item(KIND_BLEND, 255,  255,  8'hff, 8'h00, 8'h80, 8'd254);
        // origin: blend onto transparent black, then a weaker alpha keeps
        // the stronger canvas alpha, then opaque white and black
        send_item(KIND_BLEND, 0,    0,    8'd200, 8'd100, 8'd50, 8'd100);
        send_item(KIND_BLEND, 0,    0,    8'd10,  8'd20,  8'd30, 8'd50);
        send_item(KIND_BLEND, 0,    0,    8'hff, 8'hff, 8'hff, ALPHA_OPAQUE);
        send_item(KIND_BLEND, 0,    0,    8'h00, 8'h00, 8'h00, ALPHA_OPAQUE);
        send_item(KIND_READ,  0,    0,    8'h00, 8'h00, 8'h00, 8'h00);
        // other corners
        send_item(KIND_BLEND, 255,  0,    8'hff, 8'hff, 8'hff, ALPHA_CLEAR);
        send_item(KIND_BLEND, 0,    255,  8'hff, 8'h01, 8'hfe, 8'd254);
        send_item(KIND_READ,  -1,   -1,   8'h00, 8'h00, 8'h00, 8'h00);
        send_item(KIND_READ,  256,  255,  8'h00, 8'h00, 8'h00, 8'h00);
        send_item(KIND_READ,  0,    255,  8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // config is taken during the clear sweep; items wait on s_tready
        set_canvas(WIDTH_SET[0], HEIGHT_SET[0]);
        run_directed();
        for (int p = 0; p < N_SETTINGS; p++) begin
            // size changes only with the pipe empty
            if (p != 0) begin
                settle();
                set_canvas(WIDTH_SET[p], HEIGHT_SET[p]);
            end
            calm <= (p == CALM_SETTING);
            repeat (ITEMS_PER_SETTING) send_random();
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d items over %0d canvas sizes, %0d results checked, %0d errors",
                 sent, N_SETTINGS, sb.checked, sb.errors);
        $display("Results by status: opaque %0d, blended %0d, skipped %0d, clipped %0d, read %0d",
                 sb.by_status[STATUS_OPAQUE], sb.by_status[STATUS_BLEND],
                 sb.by_status[STATUS_SKIP], sb.by_status[STATUS_CLIP],
                 sb.by_status[STATUS_READ]);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : tb

// ===== filelist.f =====
hw/rtl/aopc_pkg.sv
hw/rtl/aopc_ram.sv
hw/rtl/aopc_blend.sv
hw/rtl/alpha_over_pixel_compositor.sv
hw/rtl/aopc_checker.sv
verif/compositor_scoreboard_pkg.sv
verif/tb.sv
